[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the PS/2 mouse packet tracker RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define PS2MT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ps2mt assertion failed");

// Condition must never be true outside reset.
`define PS2MT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("ps2mt forbidden condition seen");

`else

`define PS2MT_ASSERT(label, clk, rst_n, prop)
`define PS2MT_NEVER(label, clk, rst_n, cond)

`endif

`endif

[hdl/ps2mt_pkg.sv]
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker package
// Widths, constants and transfer types shared by the tracker modules.
// ----------------------------------------------------------------------------
package ps2mt_pkg;

    localparam int COORD_BITS    = 12;
    localparam int BYTE_BITS     = 8;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    // Status and packet header bit positions.
    localparam int ST_FULL_BIT    = 0;
    localparam int ST_AUX_BIT     = 5;
    localparam int HEAD_VALID_BIT = 3;
    localparam int BTN_LEFT_BIT   = 0;
    localparam int BTN_RIGHT_BIT  = 1;
    localparam int BTN_MIDDLE_BIT = 2;

    typedef logic [COORD_BITS-1:0] coord_t;

    localparam coord_t WIDTH_RESET  = 12'd1024;
    localparam coord_t HEIGHT_RESET = 12'd768;

    // Register index, taken from paddr[2].
    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0] ctrl_status;
        logic [BYTE_BITS-1:0] rx_byte;
    } in_t;

    typedef struct packed {
        coord_t                      pos_x_out;
        coord_t                      pos_y_out;
        logic signed [BYTE_BITS-1:0] delta_x;
        logic signed [BYTE_BITS-1:0] delta_y;
        logic                        left_button;
        logic                        right_button;
        logic                        middle_button;
    } out_t;

    // Bounds as seen by the packet core, plus a one-cycle clamp request
    // issued the cycle after a bound register write.
    typedef struct packed {
        coord_t width_bound;
        coord_t height_bound;
        logic   clamp;
    } cfg_t;

endpackage

[hdl/ps2_mouse_packet_tracker.sv]
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker
// Decodes three-byte PS/2 mouse packets into a clamped cursor position.
// ----------------------------------------------------------------------------
// Usage: each input transfer on s_* carries one controller status byte and one
// data byte. Bytes whose status lacks the output-full or the aux bit are dropped.
// Kept bytes are grouped into three-byte packets; a packet whose first byte has
// bit 3 clear is discarded, any other one moves the cursor by its signed deltas
// (y moves opposite to the packet's dy) and yields one result transfer on m_*.
// A byte lands in the input register at its transfer, then crosses the add and
// clamp logic into the result register, and m_valid is high from then on.
// Throughput is one input transfer per cycle while the receiver does not stall,
// set by the single add and clamp step between those two registers.
// When the receiver stalls, the result register holds its transfer and the
// input register still takes one more item; s_ready drops only when both hold.
// Reset clears the packet byte count and the cursor to the origin and loads
// the width and height bounds with 1024 and 768.
// The APB port holds the width bound at address 0 and the height bound at
// address 4; a write of zero leaves the bound as is, and every write pulls the
// cursor inside the bounds on the following cycle.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input byte channel.
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ps2mt_pkg::in_t                      s_data,
    // Result channel.
    output logic                                m_valid,
    input  logic                                m_ready,
    output ps2mt_pkg::out_t                     m_data,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ps2mt_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [ps2mt_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [ps2mt_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                pready
);

    ps2mt_pkg::cfg_t cfg;
    logic            res_valid;
    ps2mt_pkg::out_t res_data;
    logic            out_stall;

    // Bound registers and the clamp request that follows each write.
    ps2mt_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input register, packet assembly and cursor arithmetic.
    ps2mt_packet_core u_packet_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg       (cfg),
        .out_stall (out_stall),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    // Result register facing the downstream receiver.
    ps2mt_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_data  (res_data),
        .out_stall (out_stall),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

[hdl/ps2mt_cfg_regs.sv]
// ----------------------------------------------------------------------------
// PS/2 mouse tracker configuration registers
// APB register file holding the screen width and height bounds.
// ----------------------------------------------------------------------------
module ps2mt_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ps2mt_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [ps2mt_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [ps2mt_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                pready,
    output ps2mt_pkg::cfg_t                     cfg
);

    ps2mt_pkg::coord_t   width_reg, width_next;
    ps2mt_pkg::coord_t   height_reg, height_next;
    logic                clamp_reg, clamp_next;
    logic                wr_en;
    ps2mt_pkg::reg_idx_t wr_idx;
    ps2mt_pkg::coord_t   wr_val;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = ps2mt_pkg::reg_idx_t'(paddr[2]);
    assign wr_val = pwdata[ps2mt_pkg::COORD_BITS-1:0];

    // A zero bound is ignored, but the cursor is clamped after every write.
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        clamp_next  = wr_en;
        if (wr_en && (wr_val != '0)) begin
            case (wr_idx)
                ps2mt_pkg::REG_WIDTH:  width_next  = wr_val;
                ps2mt_pkg::REG_HEIGHT: height_next = wr_val;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= ps2mt_pkg::WIDTH_RESET;
            height_reg <= ps2mt_pkg::HEIGHT_RESET;
            clamp_reg  <= 1'b0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            clamp_reg  <= clamp_next;
        end
    end

    always_comb begin
        prdata = '0;
        case (wr_idx)
            ps2mt_pkg::REG_WIDTH:  prdata[ps2mt_pkg::COORD_BITS-1:0] = width_reg;
            ps2mt_pkg::REG_HEIGHT: prdata[ps2mt_pkg::COORD_BITS-1:0] = height_reg;
            default: ;
        endcase
    end

    assign cfg.width_bound  = width_reg;
    assign cfg.height_bound = height_reg;
    assign cfg.clamp        = clamp_reg;

endmodule

[hdl/ps2mt_packet_core.sv]
// ----------------------------------------------------------------------------
// PS/2 mouse tracker packet core
// Input register, three-byte packet assembly and clamped cursor update.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ps2mt_packet_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ps2mt_pkg::in_t    s_data,
    input  ps2mt_pkg::cfg_t   cfg,
    input  logic              out_stall,
    output logic              res_valid,
    output ps2mt_pkg::out_t   res_data
);

    localparam int SUM_BITS = ps2mt_pkg::COORD_BITS + 2;

    typedef enum logic [1:0] {
        CNT_HEAD   = 2'd0,
        CNT_SECOND = 2'd1,
        CNT_THIRD  = 2'd2
    } cnt_t;

    logic                                in_vld_reg, in_vld_next;
    ps2mt_pkg::in_t                      in_data_reg;
    cnt_t                                cnt_reg, cnt_next;
    logic [ps2mt_pkg::BYTE_BITS-1:0]     head_reg, head_next;
    logic [ps2mt_pkg::BYTE_BITS-1:0]     second_reg, second_next;
    ps2mt_pkg::coord_t                   cur_x_reg, cur_x_next;
    ps2mt_pkg::coord_t                   cur_y_reg, cur_y_next;
    ps2mt_pkg::coord_t                   base_x;
    ps2mt_pkg::coord_t                   base_y;
    logic                                fire;
    logic                                take;
    logic [SUM_BITS-1:0]                 sum_x;
    logic [SUM_BITS-1:0]                 sum_y;
    ps2mt_pkg::coord_t                   new_x;
    ps2mt_pkg::coord_t                   new_y;

    // Clamp a widened signed sum into 0..bound-1.
    function automatic ps2mt_pkg::coord_t clamp_sum(
        input logic [SUM_BITS-1:0] s,
        input ps2mt_pkg::coord_t   bound
    );
        ps2mt_pkg::coord_t r;
        if (s[SUM_BITS-1]) begin
            r = '0;
        end else if (s[SUM_BITS-2:0] >= {1'b0, bound}) begin
            r = bound - ps2mt_pkg::coord_t'(1);
        end else begin
            r = s[ps2mt_pkg::COORD_BITS-1:0];
        end
        return r;
    endfunction

    assign fire    = in_vld_reg && !out_stall;
    assign s_ready = !in_vld_reg || !out_stall;
    assign take    = fire && in_data_reg.ctrl_status[ps2mt_pkg::ST_FULL_BIT]
                          && in_data_reg.ctrl_status[ps2mt_pkg::ST_AUX_BIT];

    // After a bound write the stored cursor is pulled inside the new bounds,
    // and a packet finishing in that same cycle moves from the pulled-in spot.
    assign base_x = (cfg.clamp && (cur_x_reg >= cfg.width_bound))
                  ? cfg.width_bound - ps2mt_pkg::coord_t'(1) : cur_x_reg;
    assign base_y = (cfg.clamp && (cur_y_reg >= cfg.height_bound))
                  ? cfg.height_bound - ps2mt_pkg::coord_t'(1) : cur_y_reg;

    assign sum_x = {2'b00, base_x}
                 + {{(SUM_BITS-ps2mt_pkg::BYTE_BITS){second_reg[ps2mt_pkg::BYTE_BITS-1]}},
                    second_reg};
    assign sum_y = {2'b00, base_y}
                 - {{(SUM_BITS-ps2mt_pkg::BYTE_BITS){in_data_reg.rx_byte[ps2mt_pkg::BYTE_BITS-1]}},
                    in_data_reg.rx_byte};
    assign new_x = clamp_sum(sum_x, cfg.width_bound);
    assign new_y = clamp_sum(sum_y, cfg.height_bound);

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
        end else if (fire) begin
            in_vld_next = 1'b0;
        end
    end

    always_comb begin
        cnt_next    = cnt_reg;
        head_next   = head_reg;
        second_next = second_reg;
        cur_x_next  = base_x;
        cur_y_next  = base_y;
        res_valid   = 1'b0;

        if (take) begin
            case (cnt_reg)
                CNT_HEAD: begin
                    head_next = in_data_reg.rx_byte;
                    cnt_next  = CNT_SECOND;
                end
                CNT_SECOND: begin
                    second_next = in_data_reg.rx_byte;
                    cnt_next    = CNT_THIRD;
                end
                default: begin
                    cnt_next = CNT_HEAD;
                    if (head_reg[ps2mt_pkg::HEAD_VALID_BIT]) begin
                        cur_x_next = new_x;
                        cur_y_next = new_y;
                        res_valid  = 1'b1;
                    end
                end
            endcase
        end
    end

    assign res_data.pos_x_out     = new_x;
    assign res_data.pos_y_out     = new_y;
    assign res_data.delta_x       = second_reg;
    assign res_data.delta_y       = in_data_reg.rx_byte;
    assign res_data.left_button   = head_reg[ps2mt_pkg::BTN_LEFT_BIT];
    assign res_data.right_button  = head_reg[ps2mt_pkg::BTN_RIGHT_BIT];
    assign res_data.middle_button = head_reg[ps2mt_pkg::BTN_MIDDLE_BIT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            cnt_reg    <= CNT_HEAD;
            head_reg   <= '0;
            second_reg <= '0;
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
        end else begin
            in_vld_reg <= in_vld_next;
            cnt_reg    <= cnt_next;
            head_reg   <= head_next;
            second_reg <= second_next;
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // A result is only issued when the result register can take it.
    `PS2MT_NEVER(a_res_into_stall, aclk, aresetn, res_valid && out_stall)
    // A result always closes a packet and restarts the byte count.
    `PS2MT_ASSERT(a_res_restarts, aclk, aresetn, res_valid |=> cnt_reg == CNT_HEAD)
    // After a bound write has been applied the cursor sits inside the bounds.
    `PS2MT_ASSERT(a_clamp_x, aclk, aresetn,
        $past(cfg.clamp) |-> cur_x_reg < cfg.width_bound)
    `PS2MT_ASSERT(a_clamp_y, aclk, aresetn,
        $past(cfg.clamp) |-> cur_y_reg < cfg.height_bound)

endmodule

[hdl/ps2mt_out_reg.sv]
// ----------------------------------------------------------------------------
// PS/2 mouse tracker result register
// Holds one finished result until the downstream side takes it.
// ----------------------------------------------------------------------------
module ps2mt_out_reg (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            res_valid,
    input  ps2mt_pkg::out_t res_data,
    output logic            out_stall,
    output logic            m_valid,
    input  logic            m_ready,
    output ps2mt_pkg::out_t m_data
);

    logic            vld_reg, vld_next;
    ps2mt_pkg::out_t data_reg;

    assign out_stall = vld_reg && !m_ready;

    always_comb begin
        vld_next = vld_reg;
        if (res_valid) begin
            vld_next = 1'b1;
        end else if (m_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            data_reg <= res_data;
        end
    end

    assign m_valid = vld_reg;
    assign m_data  = data_reg;

endmodule
